// ===== rtl/clns_pkg.sv =====
// Shared types and constants for the character LCD nibble sequencer.
`timescale 1ns / 1ps

package clns_pkg;

    // Request kinds
    localparam logic [1:0] FUNC_INIT   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR  = 2'd1;
    localparam logic [1:0] FUNC_CURSOR = 2'd2;
    localparam logic [1:0] FUNC_CHAR   = 2'd3;

    // Display commands
    localparam logic [7:0] CMD_FOURBIT = 8'h28;
    localparam logic [7:0] CMD_DISPON  = 8'h0C;
    localparam logic [7:0] CMD_CURSOR  = 8'h80;
    localparam logic [7:0] CMD_CLEAR   = 8'h01;

    // Hold times in microseconds
    localparam logic [13:0] T_SETTLE   = 14'd1000;
    localparam logic [13:0] T_DATA     = 14'd11;
    localparam logic [13:0] T_EHIGH    = 14'd1;
    localparam logic [13:0] T_ELOW     = 14'd100;
    localparam logic [13:0] T_WAIT_POR = 14'd4500;
    localparam logic [13:0] T_WAIT_3RD = 14'd150;
    localparam logic [13:0] T_WAIT_ON  = 14'd10;
    localparam logic [13:0] T_WAIT_CLR = 14'd10000;

    // Phase slots within one byte run
    localparam logic [2:0] PH_SETTLE  = 3'd0;
    localparam logic [2:0] PH_HI_SET  = 3'd1;
    localparam logic [2:0] PH_HI_EN   = 3'd2;
    localparam logic [2:0] PH_HI_LOW  = 3'd3;
    localparam logic [2:0] PH_LO_SET  = 3'd4;
    localparam logic [2:0] PH_LO_EN   = 3'd5;
    localparam logic [2:0] PH_LO_LOW  = 3'd6;

    localparam logic [2:0] INIT_LAST_BYTE = 3'd5;

    // Controller to datapath command
    typedef struct packed {
        logic       capture;   // latch request fields
        logic       emit;      // load a phase into the output register
        logic       lead;      // leading power-up phase of initialize
        logic [2:0] byte_idx;  // byte within an initialize run
        logic [2:0] phase;     // phase within the byte
        logic       last;      // final phase of the run
    } clns_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;        // output register can take a phase
    } clns_stat_t;

    // Byte sent at each step of initialize
    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd4:    b = CMD_DISPON;
            3'd5:    b = CMD_CLEAR;
            default: b = CMD_FOURBIT;
        endcase
        return b;
    endfunction

    // Extra wait after each step of initialize
    function automatic logic [13:0] init_extra(input logic [2:0] idx);
        logic [13:0] w;
        unique case (idx)
            3'd0, 3'd1: w = T_WAIT_POR;
            3'd2:       w = T_WAIT_3RD;
            3'd4:       w = T_WAIT_ON;
            3'd5:       w = T_WAIT_CLR;
            default:    w = 14'd0;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/clns_ctrl.sv =====
// Sequencing state machine: walks the lead phase, bytes and phases of a run.
`timescale 1ns / 1ps

module clns_ctrl
    import clns_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] func,
    input  clns_stat_t stat,
    output clns_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LEAD = 2'd1;
    localparam logic [1:0] ST_BYTE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic [2:0] byte_reg, byte_next;
    logic       init_reg, init_next;
    logic       accept, emit, last_byte, run_last;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign emit      = (state_reg != ST_IDLE) && stat.out_free;
    assign last_byte = !init_reg || (byte_reg == INIT_LAST_BYTE);
    assign run_last  = (state_reg == ST_BYTE) && (phase_reg == PH_LO_LOW) && last_byte;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        byte_next  = byte_reg;
        init_next  = init_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    init_next  = (func == FUNC_INIT);
                    phase_next = PH_SETTLE;
                    byte_next  = 3'd0;
                    state_next = (func == FUNC_INIT) ? ST_LEAD : ST_BYTE;
                end
            end
            ST_LEAD:
            begin
                if (emit)
                    state_next = ST_BYTE;
            end
            ST_BYTE:
            begin
                if (emit)
                begin
                    if (phase_reg == PH_LO_LOW)
                    begin
                        phase_next = PH_SETTLE;
                        if (last_byte)
                            state_next = ST_IDLE;
                        else
                            byte_next = byte_reg + 3'd1;
                    end
                    else
                    begin
                        phase_next = phase_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_SETTLE;
            byte_reg  <= 3'd0;
            init_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            byte_reg  <= byte_next;
            init_reg  <= init_next;
        end
    end

    always_comb
    begin
        cmd.capture  = accept;
        cmd.emit     = emit;
        cmd.lead     = (state_reg == ST_LEAD);
        cmd.byte_idx = byte_reg;
        cmd.phase    = phase_reg;
        cmd.last     = run_last;
    end

endmodule

// ===== rtl/clns_dpath.sv =====
// Datapath: request latch, byte and phase field forming, output register.
`timescale 1ns / 1ps

module clns_dpath
    import clns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  func,
    input  logic        line,
    input  logic [5:0]  pos,
    input  logic [7:0]  char_byte,
    input  clns_cmd_t   cmd,
    output clns_stat_t  stat,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        rs,
    output logic        rw,
    output logic        enable,
    output logic [3:0]  nibble,
    output logic [13:0] hold_us,
    output logic        last
);

    logic [1:0]  func_reg;
    logic        line_reg;
    logic [5:0]  pos_reg;
    logic [7:0]  char_reg;

    logic        out_valid_reg;
    logic        rs_reg, en_reg, last_reg;
    logic [3:0]  nib_reg;
    logic [13:0] hold_reg;

    logic [7:0]  cur_byte;
    logic [13:0] cur_extra;
    logic        cur_rs;
    logic        ph_rs, ph_en;
    logic [3:0]  ph_nib;
    logic [13:0] ph_hold;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            line_reg <= line;
            pos_reg  <= pos;
            char_reg <= char_byte;
        end
    end

    // Byte, mode and trailing wait of the current byte
    always_comb
    begin
        unique case (func_reg)
            FUNC_INIT:
            begin
                cur_byte  = init_byte(cmd.byte_idx);
                cur_extra = init_extra(cmd.byte_idx);
                cur_rs    = 1'b0;
            end
            FUNC_CLEAR:
            begin
                cur_byte  = CMD_CLEAR;
                cur_extra = T_WAIT_CLR;
                cur_rs    = 1'b0;
            end
            FUNC_CURSOR:
            begin
                cur_byte  = (CMD_CURSOR | {1'b0, line_reg, 6'b0}) + {2'b00, pos_reg};
                cur_extra = 14'd0;
                cur_rs    = 1'b0;
            end
            default:
            begin
                cur_byte  = char_reg;
                cur_extra = 14'd0;
                cur_rs    = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        ph_rs = cur_rs;
        ph_en = 1'b0;
        unique case (cmd.phase)
            PH_SETTLE:
            begin
                ph_nib  = 4'h0;
                ph_hold = T_SETTLE;
            end
            PH_HI_SET:
            begin
                ph_nib  = cur_byte[7:4];
                ph_hold = T_DATA;
            end
            PH_HI_EN:
            begin
                ph_nib  = cur_byte[7:4];
                ph_en   = 1'b1;
                ph_hold = T_EHIGH;
            end
            PH_HI_LOW:
            begin
                ph_nib  = cur_byte[7:4];
                ph_hold = T_ELOW;
            end
            PH_LO_SET:
            begin
                ph_nib  = cur_byte[3:0];
                ph_hold = T_DATA;
            end
            PH_LO_EN:
            begin
                ph_nib  = cur_byte[3:0];
                ph_en   = 1'b1;
                ph_hold = T_EHIGH;
            end
            default:
            begin
                ph_nib  = cur_byte[3:0];
                ph_hold = T_ELOW + T_SETTLE + cur_extra;
            end
        endcase
        // power-up lead phase: command mode, lines idle
        if (cmd.lead)
        begin
            ph_rs   = 1'b0;
            ph_en   = 1'b0;
            ph_nib  = 4'h0;
            ph_hold = T_SETTLE;
        end
    end

    assign stat.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rs_reg   <= ph_rs;
            en_reg   <= ph_en;
            nib_reg  <= ph_nib;
            hold_reg <= ph_hold;
            last_reg <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign rs        = rs_reg;
    assign rw        = 1'b0;
    assign enable    = en_reg;
    assign nibble    = nib_reg;
    assign hold_us   = hold_reg;
    assign last      = last_reg;

endmodule

// ===== rtl/char_lcd_nibble_sequencer_top.sv =====
// Top level of the character LCD nibble sequencer.
`timescale 1ns / 1ps

// Turns one request (initialize, clear, set cursor, write character) into
// the run of 4-bit bus phases for a character LCD. Each byte is a settle
// phase followed by the high and the low nibble, each as data set, E high,
// E low: seven phases. Initialize adds one leading phase and sends six
// bytes, 43 phases in all. One phase is loaded per clock while the output
// register is free. No phase is loaded in the cycle in which a request is
// accepted. The controller's phase counter steps once per phase loaded
// within a byte and its byte counter once per byte. The final phase of
// each run carries last. A new request is taken as soon as the last phase
// of the previous run sits in the output register, even if that transfer
// has not completed yet. hold_us is passed on untouched; the downstream
// pin driver realizes the delays.

module char_lcd_nibble_sequencer_top
    import clns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic        line,
    input  logic [5:0]  pos,
    input  logic [7:0]  char_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        rs,
    output logic        rw,
    output logic        enable,
    output logic [3:0]  nibble,
    output logic [13:0] hold_us,
    output logic        last
);

    clns_cmd_t  cmd;
    clns_stat_t stat;

    // phase / byte sequencing
    clns_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .stat     (stat),
        .cmd      (cmd)
    );

    // field forming and output register
    clns_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .func      (func),
        .line      (line),
        .pos       (pos),
        .char_byte (char_byte),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .rs        (rs),
        .rw        (rw),
        .enable    (enable),
        .nibble    (nibble),
        .hold_us   (hold_us),
        .last      (last)
    );

endmodule
